@@ rtl/dnsx_pkg.sv @@
package dnsx_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_FOUND      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED  = 2'd2;
    localparam logic [1:0] STATUS_NO_ADDRESS = 2'd3;

    // Message layout constants.
    localparam logic [3:0] HEADER_LAST_OFFSET = 4'd11;
    localparam logic [3:0] ANSWER_FIXED_LEN   = 4'd10;
    localparam logic [7:0] POINTER_MASK       = 8'hC0;
    localparam logic [7:0] QR_MASK            = 8'h80;
    localparam logic [15:0] QTAIL_AFTER_ZERO  = 16'd4;
    localparam logic [15:0] QTAIL_AFTER_PTR   = 16'd5;
    localparam logic [15:0] TYPE_A            = 16'd1;
    localparam logic [15:0] ADDRESS_LEN       = 16'd4;

    // One byte handed from the input register to the parser.
    typedef struct packed {
        logic       step;
        logic [7:0] data_byte;
        logic       last;
    } t_step;

    // Result computed on the final byte of a message.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } t_result;

endpackage

@@ rtl/dnsx_parse.sv @@
module dnsx_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dnsx_pkg::t_step    i_step,
    input  logic [15:0]        i_query_id,
    output dnsx_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_QNAME  = 3'd1,
        PH_QTAIL  = 3'd2,
        PH_ANAME  = 3'd3,
        PH_APTR   = 3'd4,
        PH_AFIX   = 3'd5,
        PH_ADATA  = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_header_offset, n_header_offset;
    logic [15:0] r_skip_count, n_skip_count;
    logic [15:0] r_answers_left, n_answers_left;
    logic [3:0]  r_record_offset, n_record_offset;
    logic [15:0] r_record_type, n_record_type;
    logic [15:0] r_record_length, n_record_length;
    logic        r_header_bad, n_header_bad;
    logic        r_found, n_found;
    logic [31:0] r_address, n_address;

    logic [7:0]  b;
    logic        is_pointer;
    logic        is_candidate;
    logic [15:0] answers_dec;
    logic [1:0]  status;

    assign b            = i_step.data_byte;
    assign is_pointer   = (b & dnsx_pkg::POINTER_MASK) == dnsx_pkg::POINTER_MASK;
    assign is_candidate = (r_record_type == dnsx_pkg::TYPE_A) &&
                          (r_record_length == dnsx_pkg::ADDRESS_LEN);
    assign answers_dec  = r_answers_left - 16'd1;

    // Next parser state for the byte at the input register.
    always_comb begin
        n_phase         = r_phase;
        n_header_offset = r_header_offset;
        n_skip_count    = r_skip_count;
        n_answers_left  = r_answers_left;
        n_record_offset = r_record_offset;
        n_record_type   = r_record_type;
        n_record_length = r_record_length;
        n_header_bad    = r_header_bad;
        n_found         = r_found;
        n_address       = r_address;
        case (r_phase)
            PH_HEADER: begin
                if (r_header_offset == 4'd0 && b != i_query_id[15:8]) begin
                    n_header_bad = 1'b1;
                end
                if (r_header_offset == 4'd1 && b != i_query_id[7:0]) begin
                    n_header_bad = 1'b1;
                end
                if (r_header_offset == 4'd2 && (b & dnsx_pkg::QR_MASK) == 8'd0) begin
                    n_header_bad = 1'b1;
                end
                if (r_header_offset == 4'd6) begin
                    n_answers_left = {b, 8'd0};
                end
                if (r_header_offset == 4'd7) begin
                    n_answers_left = r_answers_left | {8'd0, b};
                end
                if (r_header_offset >= dnsx_pkg::HEADER_LAST_OFFSET) begin
                    if (r_answers_left == 16'd0) begin
                        n_header_bad = 1'b1;
                    end
                    n_phase      = n_header_bad ? PH_DONE : PH_QNAME;
                    n_skip_count = 16'd0;
                end else begin
                    n_header_offset = r_header_offset + 4'd1;
                end
            end
            PH_QNAME: begin
                if (r_skip_count != 16'd0) begin
                    n_skip_count = r_skip_count - 16'd1;
                end else if (b == 8'd0) begin
                    n_skip_count = dnsx_pkg::QTAIL_AFTER_ZERO;
                    n_phase      = PH_QTAIL;
                end else if (is_pointer) begin
                    n_skip_count = dnsx_pkg::QTAIL_AFTER_PTR;
                    n_phase      = PH_QTAIL;
                end else begin
                    n_skip_count = {8'd0, b};
                end
            end
            PH_QTAIL: begin
                n_skip_count = r_skip_count - 16'd1;
                if (n_skip_count == 16'd0) begin
                    n_record_offset = 4'd0;
                    n_phase         = PH_ANAME;
                end
            end
            PH_ANAME: begin
                if (r_skip_count != 16'd0) begin
                    n_skip_count = r_skip_count - 16'd1;
                end else if (b == 8'd0) begin
                    n_record_offset = 4'd0;
                    n_phase         = PH_AFIX;
                end else if (is_pointer) begin
                    n_phase = PH_APTR;
                end else begin
                    n_record_offset = 4'd1;
                    n_skip_count    = {8'd0, b};
                end
            end
            PH_APTR: begin
                n_record_offset = 4'd0;
                n_phase         = PH_AFIX;
            end
            PH_AFIX: begin
                if (r_record_offset == 4'd0) begin
                    n_record_type = {b, 8'd0};
                end
                if (r_record_offset == 4'd1) begin
                    n_record_type = r_record_type | {8'd0, b};
                end
                if (r_record_offset == 4'd8) begin
                    n_record_length = {b, 8'd0};
                end
                if (r_record_offset == 4'd9) begin
                    n_record_length = r_record_length | {8'd0, b};
                end
                n_record_offset = r_record_offset + 4'd1;
                if (n_record_offset >= dnsx_pkg::ANSWER_FIXED_LEN) begin
                    n_record_offset = 4'd0;
                    if (n_record_length == 16'd0) begin
                        // Empty record data: move on to the next answer.
                        n_answers_left = answers_dec;
                        n_skip_count   = 16'd0;
                        n_phase        = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    end else begin
                        n_skip_count = n_record_length;
                        n_address    = 32'd0;
                        n_phase      = PH_ADATA;
                    end
                end
            end
            PH_ADATA: begin
                if (is_candidate) begin
                    n_address = {r_address[23:0], b};
                end
                n_skip_count = r_skip_count - 16'd1;
                if (n_skip_count == 16'd0) begin
                    if (is_candidate) begin
                        n_found = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_answers_left  = answers_dec;
                        n_skip_count    = 16'd0;
                        n_record_offset = 4'd0;
                        n_phase         = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Outcome of the message if this byte is its last one.
    always_comb begin
        case (n_phase)
            PH_HEADER: status = dnsx_pkg::STATUS_BAD_HEADER;
            PH_DONE: begin
                if (n_header_bad) begin
                    status = dnsx_pkg::STATUS_BAD_HEADER;
                end else if (n_found) begin
                    status = dnsx_pkg::STATUS_FOUND;
                end else begin
                    status = dnsx_pkg::STATUS_NO_ADDRESS;
                end
            end
            PH_ANAME: begin
                status = (n_record_offset != 4'd0 || n_skip_count != 16'd0) ?
                         dnsx_pkg::STATUS_TRUNCATED : dnsx_pkg::STATUS_NO_ADDRESS;
            end
            PH_APTR:  status = dnsx_pkg::STATUS_TRUNCATED;
            PH_AFIX:  status = dnsx_pkg::STATUS_TRUNCATED;
            default:  status = dnsx_pkg::STATUS_NO_ADDRESS;
        endcase
    end

    assign o_result.status  = status;
    assign o_result.address = (status == dnsx_pkg::STATUS_FOUND) ? n_address : 32'd0;

    // Parser state; the final byte of a message returns it to the header phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.step && i_step.last)) begin
            r_phase         <= PH_HEADER;
            r_header_offset <= 4'd0;
            r_skip_count    <= 16'd0;
            r_answers_left  <= 16'd0;
            r_record_offset <= 4'd0;
            r_record_type   <= 16'd0;
            r_record_length <= 16'd0;
            r_header_bad    <= 1'b0;
            r_found         <= 1'b0;
            r_address       <= 32'd0;
        end else if (i_step.step) begin
            r_phase         <= n_phase;
            r_header_offset <= n_header_offset;
            r_skip_count    <= n_skip_count;
            r_answers_left  <= n_answers_left;
            r_record_offset <= n_record_offset;
            r_record_type   <= n_record_type;
            r_record_length <= n_record_length;
            r_header_bad    <= n_header_bad;
            r_found         <= n_found;
            r_address       <= n_address;
        end
    end

endmodule

@@ rtl/dns_answer_address_extractor_core.sv @@
// A message's last byte passes the input register and the parser into the result register.
// Throughput: one byte per cycle unless stalled; parser updates once per byte in one pass.
// The input side stalls only when a final byte waits behind a result the sink has not taken.
// Reset (i_rst_n low, synchronous) clears the parser, both pipeline valids and query_id.
module dns_answer_address_extractor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_query_id,
    // Input byte channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_address
);

    logic [15:0]       r_query_id;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [31:0]       r_out_address;

    logic              out_free;
    logic              advance;
    logic              in_accept;
    dnsx_pkg::t_step   step;
    dnsx_pkg::t_result result;

    // The input register moves on unless its final byte needs a busy result register.
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && (!r_in_last || out_free);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_query_id <= i_query_id;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    assign step.step      = advance;
    assign step.data_byte = r_in_byte;
    assign step.last      = r_in_last;

    dnsx_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_query_id (r_query_id),
        .o_result   (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_status  <= result.status;
            r_out_address <= result.address;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_address = r_out_address;

endmodule

@@ rtl/dnsx_checker.sv @@
module dnsx_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_status,
    input  logic [31:0] o_address
);

    // A stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_address))
        else $error("result changed while stalled");

    // Only a found address carries a nonzero address.
    a_address_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != dnsx_pkg::STATUS_FOUND |-> o_address == 32'd0)
        else $error("nonzero address without a found status");

    // Reset empties both pipeline registers.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind dns_answer_address_extractor_core dnsx_checker u_dnsx_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_status  (o_status),
    .o_address (o_address)
);

@@ dv/dns_answer_checker.sv @@
module dns_answer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_query_id,
    // Input byte channel.
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    // Result channel.
    input  logic        i_result_valid,
    input  logic        i_result_stall,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_address,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_QNAME,
        SCAN_QTAIL,
        SCAN_ANAME,
        SCAN_APTR,
        SCAN_AFIX,
        SCAN_ADATA,
        SCAN_DONE
    } t_scan_phase;

    // Parser state mirrored from the message walk.
    logic [15:0] want_qid;
    t_scan_phase scan_phase;
    logic [3:0]  hdr_pos;
    logic [15:0] skip_left;
    logic [15:0] answers_todo;
    logic [3:0]  rec_pos;
    logic [15:0] rr_type;
    logic [15:0] rr_len;
    logic        hdr_fail;
    logic        addr_found;
    logic [31:0] addr_acc;

    // Results predicted for messages whose final byte has been accepted.
    dnsx_pkg::t_result expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task clear_scan();
        scan_phase   = SCAN_HEADER;
        hdr_pos      = '0;
        skip_left    = '0;
        answers_todo = '0;
        rec_pos      = '0;
        rr_type      = '0;
        rr_len       = '0;
        hdr_fail     = 1'b0;
        addr_found   = 1'b0;
        addr_acc     = '0;
    endtask

    task step_to_next_answer();
        answers_todo = answers_todo - 16'd1;
        skip_left    = '0;
        rec_pos      = '0;
        scan_phase   = (answers_todo == 16'd0) ? SCAN_DONE : SCAN_ANAME;
    endtask

    // Advance the message walk by one byte.
    task scan_byte(input logic [7:0] b);
        case (scan_phase)
            SCAN_HEADER: begin
                if (hdr_pos == 4'd0 && b != want_qid[15:8]) hdr_fail = 1'b1;
                if (hdr_pos == 4'd1 && b != want_qid[7:0]) hdr_fail = 1'b1;
                if (hdr_pos == 4'd2 && (b & dnsx_pkg::QR_MASK) == 8'h00) hdr_fail = 1'b1;
                if (hdr_pos == 4'd6) answers_todo = {b, 8'h00};
                if (hdr_pos == 4'd7) answers_todo = answers_todo | {8'h00, b};
                if (hdr_pos >= dnsx_pkg::HEADER_LAST_OFFSET) begin
                    if (answers_todo == 16'd0) hdr_fail = 1'b1;
                    scan_phase = hdr_fail ? SCAN_DONE : SCAN_QNAME;
                    skip_left  = '0;
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            SCAN_QNAME: begin
                if (skip_left != 16'd0) begin
                    skip_left = skip_left - 16'd1;
                end else if (b == 8'h00) begin
                    skip_left  = dnsx_pkg::QTAIL_AFTER_ZERO;
                    scan_phase = SCAN_QTAIL;
                end else if ((b & dnsx_pkg::POINTER_MASK) == dnsx_pkg::POINTER_MASK) begin
                    skip_left  = dnsx_pkg::QTAIL_AFTER_PTR;
                    scan_phase = SCAN_QTAIL;
                end else begin
                    skip_left = {8'h00, b};
                end
            end
            SCAN_QTAIL: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0) begin
                    rec_pos    = '0;
                    scan_phase = SCAN_ANAME;
                end
            end
            SCAN_ANAME: begin
                if (skip_left != 16'd0) begin
                    skip_left = skip_left - 16'd1;
                end else if (b == 8'h00) begin
                    rec_pos    = '0;
                    scan_phase = SCAN_AFIX;
                end else if ((b & dnsx_pkg::POINTER_MASK) == dnsx_pkg::POINTER_MASK) begin
                    scan_phase = SCAN_APTR;
                end else begin
                    rec_pos   = 4'd1;
                    skip_left = {8'h00, b};
                end
            end
            SCAN_APTR: begin
                rec_pos    = '0;
                scan_phase = SCAN_AFIX;
            end
            SCAN_AFIX: begin
                if (rec_pos == 4'd0) rr_type = {b, 8'h00};
                if (rec_pos == 4'd1) rr_type = rr_type | {8'h00, b};
                if (rec_pos == 4'd8) rr_len = {b, 8'h00};
                if (rec_pos == 4'd9) rr_len = rr_len | {8'h00, b};
                rec_pos = rec_pos + 4'd1;
                if (rec_pos >= dnsx_pkg::ANSWER_FIXED_LEN) begin
                    rec_pos = '0;
                    if (rr_len == 16'd0) begin
                        step_to_next_answer();
                    end else begin
                        skip_left  = rr_len;
                        addr_acc   = '0;
                        scan_phase = SCAN_ADATA;
                    end
                end
            end
            SCAN_ADATA: begin
                if (rr_type == dnsx_pkg::TYPE_A && rr_len == dnsx_pkg::ADDRESS_LEN)
                    addr_acc = {addr_acc[23:0], b};
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0) begin
                    if (rr_type == dnsx_pkg::TYPE_A && rr_len == dnsx_pkg::ADDRESS_LEN) begin
                        addr_found = 1'b1;
                        scan_phase = SCAN_DONE;
                    end else begin
                        step_to_next_answer();
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Result of a message at its final byte.
    function automatic dnsx_pkg::t_result message_result();
        dnsx_pkg::t_result r;
        case (scan_phase)
            SCAN_HEADER: r.status = dnsx_pkg::STATUS_BAD_HEADER;
            SCAN_DONE: begin
                if (hdr_fail) r.status = dnsx_pkg::STATUS_BAD_HEADER;
                else r.status = addr_found ? dnsx_pkg::STATUS_FOUND
                                           : dnsx_pkg::STATUS_NO_ADDRESS;
            end
            SCAN_ANAME: begin
                r.status = (rec_pos != 4'd0 || skip_left != 16'd0) ?
                           dnsx_pkg::STATUS_TRUNCATED : dnsx_pkg::STATUS_NO_ADDRESS;
            end
            SCAN_APTR, SCAN_AFIX: r.status = dnsx_pkg::STATUS_TRUNCATED;
            default: r.status = dnsx_pkg::STATUS_NO_ADDRESS;
        endcase
        r.address = (r.status == dnsx_pkg::STATUS_FOUND) ? addr_acc : 32'd0;
        return r;
    endfunction

    // Watch all three channels on each edge; results are compared before new bytes.
    always @(posedge i_clk) begin : watch
        dnsx_pkg::t_result want;
        if (!i_rst_n) begin
            want_qid = '0;
            clear_scan();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) want_qid = i_query_id;

            if (i_result_valid && !i_result_stall) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: status %0d address %h",
                                 i_status, i_address);
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_status || want.address !== i_address) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: status exp %0d got %0d, address exp %h got %h",
                                     want.status, i_status, want.address, i_address);
                    end
                end
            end

            if (i_byte_valid && !i_byte_stall) begin
                scan_byte(i_data_byte);
                if (i_last) begin
                    expected_results.push_back(message_result());
                    clear_scan();
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_query_id;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [31:0] o_address;

    int fail_count;
    int pending;

    // Traffic shaping knobs.
    int src_idle_pct;
    int sink_idle_pct;
    int hold_len;
    int hold_gen;
    int seen_gen;
    int hold_left;
    int cycle_count;

    logic [15:0] cur_qid;
    logic [7:0]  msg_q[$];

    dns_answer_address_extractor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_query_id  (i_query_id),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_address   (o_address)
    );

    dns_answer_checker u_answer_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_query_id     (i_query_id),
        .i_byte_valid   (i_valid),
        .i_byte_stall   (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .i_result_valid (o_valid),
        .i_result_stall (i_stall),
        .i_status       (o_status),
        .i_address      (o_address),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result sink: random stalls, plus a long hold-off when one is requested.
    initial begin
        i_stall   <= 1'b0;
        seen_gen  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_gen != seen_gen) begin
                seen_gen  = hold_gen;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_idle_pct);
            end
        end
    end

    task automatic push_rand(input int n);
        repeat (n) msg_q.push_back(8'($urandom));
    endtask

    task automatic push_label(input int len);
        msg_q.push_back(8'(len));
        push_rand(len);
    endtask

    task automatic push_header(input logic [15:0] id, input logic qr,
                               input logic [15:0] ancount);
        msg_q.push_back(id[15:8]);
        msg_q.push_back(id[7:0]);
        msg_q.push_back({qr, 7'($urandom)});
        push_rand(3);
        msg_q.push_back(ancount[15:8]);
        msg_q.push_back(ancount[7:0]);
        push_rand(4);
    endtask

    // A name of short labels that ends in a pointer or a zero label.
    task automatic push_name(input bit use_ptr, input int nlabels);
        repeat (nlabels) push_label($urandom_range(1, 5));
        if (use_ptr) begin
            msg_q.push_back(dnsx_pkg::POINTER_MASK | 8'($urandom_range(63)));
            push_rand(1);
        end else begin
            msg_q.push_back(8'h00);
        end
    endtask

    task automatic push_question(input bit use_ptr, input int nlabels);
        push_name(use_ptr, nlabels);
        push_rand(4);
    endtask

    task automatic push_record_head(input logic [15:0] rtype, input logic [15:0] rlen);
        msg_q.push_back(rtype[15:8]);
        msg_q.push_back(rtype[7:0]);
        push_rand(6);
        msg_q.push_back(rlen[15:8]);
        msg_q.push_back(rlen[7:0]);
    endtask

    task automatic push_a_answer(input bit use_ptr, input int nlabels, input logic [31:0] addr);
        push_name(use_ptr, nlabels);
        push_record_head(dnsx_pkg::TYPE_A, dnsx_pkg::ADDRESS_LEN);
        msg_q.push_back(addr[31:24]);
        msg_q.push_back(addr[23:16]);
        msg_q.push_back(addr[15:8]);
        msg_q.push_back(addr[7:0]);
    endtask

    // Offer one byte and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Send the first keep bytes of the built message; keep of 0 sends all of it.
    task automatic send_msg(input int keep);
        int n;
        n = (keep <= 0 || keep > msg_q.size()) ? msg_q.size() : keep;
        for (int k = 0; k < n; k++) send_byte(msg_q[k], k == n - 1);
        msg_q.delete();
    endtask

    // Stop sending and let every pending result drain.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_query_id(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_query_id  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_qid = v;
    endtask

    // Mostly well-formed responses with random content, some broken or cut short.
    task automatic send_random_message();
        logic [15:0] id;
        logic [15:0] ancount;
        logic [15:0] rtype;
        logic [15:0] rlen;
        int nrec;
        int pick;
        int keep;
        id = ($urandom_range(99) < 90) ? cur_qid : 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 5) ancount = 16'd0;
        else if (pick < 90) ancount = 16'($urandom_range(1, 3));
        else ancount = 16'($urandom);
        push_header(id, $urandom_range(99) < 92, ancount);
        if ($urandom_range(99) < 5) push_label($urandom_range(64, 191));
        push_question(1'($urandom_range(1)), $urandom_range(3));
        nrec = (ancount == 16'd0) ? 1 : ((ancount > 16'd4) ? 4 : int'(ancount));
        for (int r = 0; r < nrec; r++) begin
            pick = $urandom_range(99);
            if (pick < 60) push_name(1'b1, 0);
            else if (pick < 90) push_name(1'b0, $urandom_range(1, 3));
            else push_name(1'b1, $urandom_range(1, 2));
            pick = $urandom_range(99);
            if (pick < 60) rtype = dnsx_pkg::TYPE_A;
            else if (pick < 85) rtype = 16'($urandom_range(2, 40));
            else rtype = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 70 && rtype == dnsx_pkg::TYPE_A) rlen = dnsx_pkg::ADDRESS_LEN;
            else if (pick < 95) rlen = 16'($urandom_range(8));
            else rlen = 16'($urandom);
            push_record_head(rtype, rlen);
            if (rlen > 16'd8) begin
                push_rand($urandom_range(8));
                break;
            end
            push_rand(int'(rlen));
        end
        if ($urandom_range(99) < 20) push_rand($urandom_range(1, 3));
        keep = ($urandom_range(99) < 30) ? $urandom_range(1, msg_q.size()) : 0;
        send_msg(keep);
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_query_id  <= '0;
        i_valid     <= 1'b0;
        i_data_byte <= '0;
        i_last      <= 1'b0;
        src_idle_pct = 25;
        sink_idle_pct <= 49;
        hold_len <= 0;
        hold_gen <= 0;
        cur_qid = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_query_id(16'hFFFF);

        // Short message, then a single byte, then a bare header.
        push_header(cur_qid, 1'b1, 16'd1);
        send_msg(5);
        push_rand(1);
        send_msg(0);
        push_header(cur_qid, 1'b1, 16'd1);
        send_msg(0);

        // Header failures: wrong ID in each byte, QR clear, no answers.
        push_header(cur_qid ^ 16'h8000, 1'b1, 16'd1);
        send_msg(0);
        push_header(cur_qid ^ 16'h0001, 1'b1, 16'd1);
        send_msg(0);
        push_header(cur_qid, 1'b0, 16'd1);
        send_msg(0);
        push_header(cur_qid, 1'b1, 16'd0);
        push_question(1'b0, 1);
        push_a_answer(1'b1, 0, 32'($urandom));
        send_msg(0);

        // Found addresses at both extremes, with both name endings, the largest
        // answer count and trailing bytes.
        push_header(cur_qid, 1'b1, 16'hFFFF);
        push_question(1'b0, 2);
        push_a_answer(1'b1, 0, 32'hFFFF_FFFF);
        send_msg(0);
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b1, 0);
        push_a_answer(1'b0, 1, 32'h0000_0000);
        push_rand(3);
        send_msg(0);

        // Answer labels with only one of the top two bits set, cut short inside the label.
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b1, 0);
        push_label(64);
        send_msg(30);
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b1, 0);
        push_label(128);
        send_msg(30);

        // Message ends inside the question tail.
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b0, 1);
        send_msg(msg_q.size() - 2);

        // Message ends exactly between two answers.
        push_header(cur_qid, 1'b1, 16'd2);
        push_question(1'b1, 0);
        push_name(1'b1, 0);
        push_record_head(16'd5, 16'd2);
        push_rand(2);
        send_msg(0);

        // Directed cases continue with the receiver idling less than the sender.
        settle();
        src_idle_pct = 49;
        sink_idle_pct <= 25;
        write_query_id(16'h0000);

        // Message ends in an answer label, after a pointer byte, and in the fixed part.
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b0, 0);
        push_label(3);
        send_msg(msg_q.size() - 1);
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b0, 0);
        msg_q.push_back(dnsx_pkg::POINTER_MASK);
        send_msg(0);
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b1, 0);
        push_a_answer(1'b1, 0, 32'($urandom));
        send_msg(msg_q.size() - 6);

        // Message ends inside the data of an address record.
        push_header(cur_qid, 1'b1, 16'd1);
        push_question(1'b1, 0);
        push_a_answer(1'b1, 0, 32'($urandom));
        send_msg(msg_q.size() - 2);

        // A zero-length record and an address type of the wrong length are skipped;
        // the next one is found.
        push_header(cur_qid, 1'b1, 16'd3);
        push_question(1'b0, 1);
        push_name(1'b0, 1);
        push_record_head(16'd16, 16'd0);
        push_name(1'b1, 0);
        push_record_head(dnsx_pkg::TYPE_A, 16'd5);
        push_rand(5);
        push_a_answer(1'b0, 2, 32'($urandom));
        send_msg(0);

        // All answers walked without a four-byte address record, then trailing bytes.
        push_header(cur_qid, 1'b1, 16'd2);
        push_question(1'b0, 1);
        push_name(1'b1, 0);
        push_record_head(16'd28, dnsx_pkg::ADDRESS_LEN);
        push_rand(4);
        push_name(1'b1, 0);
        push_record_head(dnsx_pkg::TYPE_A, 16'd2);
        push_rand(2);
        push_rand(2);
        send_msg(0);

        send_random_message();

        // No idling; first a long receiver hold-off so the block backs up.
        settle();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        write_query_id(16'($urandom));
        hold_len <= 150;
        hold_gen <= hold_gen + 1;
        repeat (3) begin
            push_header(cur_qid, 1'b1, 16'd0);
            send_msg(0);
        end
        settle();
        send_random_message();

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
